>>> rtl/core/tlct_pkg.sv
// ----------------------------------------------------------------------------
// Two-link computed torque: shared package
// Fixed-point constants, the arctangent table of the rotation pipeline,
// register indexes and the structures passed between the pipeline parts.
// ----------------------------------------------------------------------------
package tlct_pkg;

  localparam int unsigned DW           = 16;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int unsigned ANG_W        = 28;
  localparam int unsigned XY_W         = 27;
  localparam int unsigned SC_W         = 17;
  localparam int unsigned MOD_W        = 29;

  localparam logic signed [14:0] LEN_L1  = 15'sd11141;
  localparam logic signed [12:0] LEN_L2C = 13'sd2949;
  localparam logic signed [13:0] LEN_L1C = 14'sd5571;
  localparam logic signed [20:0] GRAV    = 21'sd642908;
  localparam logic signed [17:0] INER1   = 18'sd67248;
  localparam logic signed [15:0] INER2   = 16'sd20832;

  localparam logic signed [MOD_W-1:0] TWO_PI_Q24  = 29'sd105414357;
  localparam logic signed [MOD_W-1:0] FOUR_PI_Q24 = 29'sd210828714;
  localparam logic signed [MOD_W-1:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [MOD_W-1:0] HALF_PI_Q24 = 29'sd26353589;
  localparam logic signed [XY_W-1:0]  CORDIC_K    = 27'sd10188014;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  localparam logic [DW-1:0] GAIN_P_RST       = 16'd128;
  localparam logic [DW-1:0] GAIN_D_RST       = 16'd0;
  localparam logic [DW-1:0] MASS_FIRST_RST   = 16'd328;
  localparam logic [DW-1:0] MASS_SECOND_RST  = 16'd819;
  localparam logic [DW-1:0] TORQUE_SCALE_RST = 16'd2048;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_D       = 3'd1,
    REG_MASS_FIRST   = 3'd2,
    REG_MASS_SECOND  = 3'd3,
    REG_TORQUE_SCALE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ANG_W-1:0] r;
    logic                    flip;
  } ang_t;

  typedef struct packed {
    logic signed [DW-1:0] ra1;
    logic signed [DW-1:0] ra2;
    logic signed [31:0]   w1sq;
    logic signed [33:0]   w2sq;
  } side_t;

  typedef struct packed {
    logic signed [SC_W-1:0] c1;
    logic signed [SC_W-1:0] s2;
    logic signed [SC_W-1:0] c2;
    logic signed [SC_W-1:0] s12;
    logic signed [SC_W-1:0] c12;
    side_t                  side;
  } dyn_in_t;

  typedef struct packed {
    logic signed [DW-1:0] torque_one;
    logic signed [DW-1:0] torque_two;
    logic signed [DW-1:0] ref_accel_one;
    logic signed [DW-1:0] ref_accel_two;
  } res_t;

  function automatic logic signed [DW-1:0] sat16(logic signed [39:0] v);
    logic signed [DW-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tlct_ref.sv
// ----------------------------------------------------------------------------
// Two-link computed torque: reference stage
// Forms both saturated reference accelerations and the squared joint rates,
// and reduces the three joint angles to the rotation range with a fold flag.
// ----------------------------------------------------------------------------
module tlct_ref (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [tlct_pkg::DW-1:0] angle_one_i,
  input  logic signed [tlct_pkg::DW-1:0] angle_two_i,
  input  logic signed [tlct_pkg::DW-1:0] rate_one_i,
  input  logic signed [tlct_pkg::DW-1:0] rate_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_angle_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_angle_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_rate_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_rate_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_accel_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_accel_two_i,
  input  logic signed [tlct_pkg::DW-1:0] gain_p_i,
  input  logic signed [tlct_pkg::DW-1:0] gain_d_i,
  output logic                           valid_o,
  output tlct_pkg::side_t                side_o,
  output tlct_pkg::ang_t                 ang1_o,
  output tlct_pkg::ang_t                 ang2_o,
  output tlct_pkg::ang_t                 ang12_o
);

  function automatic logic signed [tlct_pkg::MOD_W-1:0] reduce(
    logic signed [tlct_pkg::MOD_W-1:0] v
  );
    logic signed [tlct_pkg::MOD_W-1:0] r;
    if (v >= tlct_pkg::FOUR_PI_Q24) begin
      r = v - tlct_pkg::FOUR_PI_Q24;
    end else if (v >= tlct_pkg::TWO_PI_Q24) begin
      r = v - tlct_pkg::TWO_PI_Q24;
    end else if (v <= -tlct_pkg::FOUR_PI_Q24) begin
      r = v + tlct_pkg::FOUR_PI_Q24;
    end else if (v <= -tlct_pkg::TWO_PI_Q24) begin
      r = v + tlct_pkg::TWO_PI_Q24;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic tlct_pkg::ang_t fold(logic signed [tlct_pkg::MOD_W-1:0] v);
    logic signed [tlct_pkg::MOD_W-1:0] w;
    tlct_pkg::ang_t                    a;
    w = v;
    if (w > tlct_pkg::PI_Q24) begin
      w = w - tlct_pkg::TWO_PI_Q24;
    end else if (w < -tlct_pkg::PI_Q24) begin
      w = w + tlct_pkg::TWO_PI_Q24;
    end
    a.flip = 1'b0;
    if (w > tlct_pkg::HALF_PI_Q24) begin
      w      = tlct_pkg::PI_Q24 - w;
      a.flip = 1'b1;
    end else if (w < -tlct_pkg::HALF_PI_Q24) begin
      w      = -tlct_pkg::PI_Q24 - w;
      a.flip = 1'b1;
    end
    a.r = w[tlct_pkg::ANG_W-1:0];
    return a;
  endfunction

  logic signed [16:0] er1, er2, ea1, ea2, w2, a12;
  logic signed [32:0] dp1_d, dp2_d, pp1_d, pp2_d;
  logic signed [31:0] w1sq_d;
  logic signed [33:0] w2sq_d;
  logic signed [tlct_pkg::MOD_W-1:0] v1, v2, v12;

  logic signed [32:0] dp1_q, dp2_q, pp1_q, pp2_q;
  logic signed [tlct_pkg::DW-1:0] acc1_q, acc2_q;
  logic signed [31:0] w1sq_q;
  logic signed [33:0] w2sq_q;
  logic signed [tlct_pkg::MOD_W-1:0] rm1_q, rm2_q, rm12_q;
  logic valid1_q, valid2_q;

  logic signed [34:0] sum1, sum2, rr1, rr2;

  tlct_pkg::side_t side_q;
  tlct_pkg::ang_t  ang1_q, ang2_q, ang12_q;

  assign er1    = want_rate_one_i - rate_one_i;
  assign er2    = want_rate_two_i - rate_two_i;
  assign ea1    = want_angle_one_i - angle_one_i;
  assign ea2    = want_angle_two_i - angle_two_i;
  assign w2     = rate_one_i + rate_two_i;
  assign a12    = angle_one_i + angle_two_i;
  assign dp1_d  = gain_d_i * er1;
  assign dp2_d  = gain_d_i * er2;
  assign pp1_d  = gain_p_i * ea1;
  assign pp2_d  = gain_p_i * ea2;
  assign w1sq_d = rate_one_i * rate_one_i;
  assign w2sq_d = w2 * w2;
  assign v1     = {angle_one_i[tlct_pkg::DW-1], angle_one_i, 12'd0};
  assign v2     = {angle_two_i[tlct_pkg::DW-1], angle_two_i, 12'd0};
  assign v12    = {a12, 12'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp1_q  <= dp1_d;
      dp2_q  <= dp2_d;
      pp1_q  <= pp1_d;
      pp2_q  <= pp2_d;
      acc1_q <= want_accel_one_i;
      acc2_q <= want_accel_two_i;
      w1sq_q <= w1sq_d;
      w2sq_q <= w2sq_d;
      rm1_q  <= reduce(v1);
      rm2_q  <= reduce(v2);
      rm12_q <= reduce(v12);
    end
  end

  assign sum1 = (acc1_q <<< 8) + dp1_q + pp1_q;
  assign sum2 = (acc2_q <<< 8) + dp2_q + pp2_q;
  assign rr1  = (sum1 + 128) >>> 8;
  assign rr2  = (sum2 + 128) >>> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q.ra1  <= tlct_pkg::sat16(rr1);
      side_q.ra2  <= tlct_pkg::sat16(rr2);
      side_q.w1sq <= w1sq_q;
      side_q.w2sq <= w2sq_q;
      ang1_q      <= fold(rm1_q);
      ang2_q      <= fold(rm2_q);
      ang12_q     <= fold(rm12_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign side_o  = side_q;
  assign ang1_o  = ang1_q;
  assign ang2_o  = ang2_q;
  assign ang12_o = ang12_q;

endmodule

>>> rtl/core/tlct_cordic.sv
// ----------------------------------------------------------------------------
// Two-link computed torque: rotation pipeline
// Pipelined CORDIC, one micro-rotation per stage, giving sine and cosine of
// a folded angle, rounded to Q.14, with the cosine negated for a folded angle.
// ----------------------------------------------------------------------------
module tlct_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  tlct_pkg::ang_t                      ang_i,
  output logic signed [tlct_pkg::SC_W-1:0]    sin_o,
  output logic signed [tlct_pkg::SC_W-1:0]    cos_o
);

  localparam int unsigned LAST = tlct_pkg::CORDIC_STEPS - 1;

  logic signed [tlct_pkg::XY_W-1:0]  x_q [tlct_pkg::CORDIC_STEPS];
  logic signed [tlct_pkg::XY_W-1:0]  y_q [tlct_pkg::CORDIC_STEPS];
  logic signed [tlct_pkg::ANG_W-1:0] r_q [tlct_pkg::CORDIC_STEPS];
  logic                              f_q [tlct_pkg::CORDIC_STEPS];

  logic signed [tlct_pkg::XY_W-1:0] xb, yb, xs, ys;
  logic signed [tlct_pkg::SC_W-1:0] sin_q, cos_q, xr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= tlct_pkg::CORDIC_K;
      f_q[0] <= ang_i.flip;
      if (!ang_i.r[tlct_pkg::ANG_W-1]) begin
        y_q[0] <= tlct_pkg::CORDIC_K;
        r_q[0] <= ang_i.r - tlct_pkg::ATAN_TAB[0];
      end else begin
        y_q[0] <= -tlct_pkg::CORDIC_K;
        r_q[0] <= ang_i.r + tlct_pkg::ATAN_TAB[0];
      end
      for (int i = 1; i < tlct_pkg::CORDIC_STEPS; i++) begin
        if (!r_q[i-1][tlct_pkg::ANG_W-1]) begin
          x_q[i] <= x_q[i-1] - (y_q[i-1] >>> i);
          y_q[i] <= y_q[i-1] + (x_q[i-1] >>> i);
          r_q[i] <= r_q[i-1] - tlct_pkg::ATAN_TAB[i];
        end else begin
          x_q[i] <= x_q[i-1] + (y_q[i-1] >>> i);
          y_q[i] <= y_q[i-1] - (x_q[i-1] >>> i);
          r_q[i] <= r_q[i-1] + tlct_pkg::ATAN_TAB[i];
        end
        f_q[i] <= f_q[i-1];
      end
      sin_q <= ys[tlct_pkg::SC_W-1:0];
      cos_q <= f_q[LAST] ? -xr : xr;
    end
  end

  assign xb    = x_q[LAST] + 512;
  assign yb    = y_q[LAST] + 512;
  assign xs    = xb >>> 10;
  assign ys    = yb >>> 10;
  assign xr    = xs[tlct_pkg::SC_W-1:0];
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/core/tlct_dyn.sv
// ----------------------------------------------------------------------------
// Two-link computed torque: dynamics pipeline
// Newton-Euler recursion for both links in ten register stages: link
// accelerations, joint torques, torque scaling and saturation.
// ----------------------------------------------------------------------------
module tlct_dyn (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  tlct_pkg::dyn_in_t              in_i,
  input  logic [tlct_pkg::DW-1:0]        mass_first_i,
  input  logic [tlct_pkg::DW-1:0]        mass_second_i,
  input  logic signed [tlct_pkg::DW-1:0] torque_scale_i,
  output logic                           valid_o,
  output tlct_pkg::res_t                 res_o
);

  localparam int unsigned DYN_LAT = 10;

  logic signed [16:0] m1s, m2s;
  logic signed [29:0] kl2m2_q;
  logic signed [32:0] ki2m2_q;
  logic signed [30:0] kl1cm1_q;
  logic signed [31:0] kl1m2_q;
  logic signed [34:0] ki1m1_q;

  logic vld_q [DYN_LAT];

  // Stage 1
  logic signed [16:0] acc2_d;
  logic signed [37:0] gc1_1, gs12_1, gc12_1;
  logic signed [30:0] l1ra_1;
  logic signed [29:0] l1cra_1, l2acc_1;
  logic signed [48:0] wc_1, ws_1;
  logic signed [46:0] l2w2_1;
  logic signed [16:0] acc2_1, s2_1, c2_1;
  logic signed [15:0] ra1_1, ra2_1;
  // Stage 2
  logic signed [63:0] lwc_full, lws_full;
  logic signed [47:0] ta_2, tb_2;
  logic signed [58:0] lwc_2, lws_2;
  logic signed [37:0] gc1_2, gs12_2, gc12_2;
  logic signed [29:0] l1cra_2, l2acc_2;
  logic signed [46:0] l2w2_2;
  logic signed [16:0] acc2_2, s2_2, c2_2;
  logic signed [15:0] ra1_2, ra2_2;
  // Stage 3
  logic signed [49:0] v1y_sum, v2x_sum, v2y_sum, v1y_rnd, v2x_rnd, v2y_rnd;
  logic signed [30:0] v1y_3, v2x_3, v2y_3;
  logic signed [16:0] acc2_3, s2_3, c2_3;
  logic signed [15:0] ra1_3, ra2_3;
  // Stage 4
  logic signed [60:0] q1_4;
  logic signed [49:0] q2_4;
  logic signed [61:0] q3_4;
  logic signed [47:0] q4_4, q5_4;
  logic signed [50:0] q6_4;
  logic signed [15:0] ra1_4, ra2_4;
  // Stage 5
  logic signed [48:0] u_sum;
  logic signed [34:0] u_5;
  logic signed [60:0] q1_5;
  logic signed [49:0] q2_5;
  logic signed [61:0] q3_5;
  logic signed [50:0] q6_5;
  logic signed [15:0] ra1_5, ra2_5;
  // Stage 6
  logic signed [18:0] u_hi;
  logic signed [16:0] u_lo;
  logic signed [50:0] uh_6;
  logic signed [48:0] ul_6;
  logic signed [60:0] q1_6;
  logic signed [49:0] q2_6;
  logic signed [61:0] q3_6;
  logic signed [50:0] q6_6;
  logic signed [15:0] ra1_6, ra2_6;
  // Stage 7
  logic signed [62:0] mid_7, t2_7, rest_7;
  logic signed [15:0] ra1_7, ra2_7;
  // Stage 8
  logic signed [62:0] t1_sum, t1_rnd, t2_rnd;
  logic signed [34:0] r1_8, r2_8;
  logic signed [15:0] ra1_8, ra2_8;
  // Stage 9
  logic signed [50:0] p1_9, p2_9;
  logic signed [15:0] ra1_9, ra2_9;
  // Stage 10
  logic signed [26:0] o1, o2;
  tlct_pkg::res_t res_q;

  assign m1s = {1'b0, mass_first_i};
  assign m2s = {1'b0, mass_second_i};

  // Mass products follow the registers; they settle while the block is idle.
  always_ff @(posedge clk_i) begin
    kl2m2_q  <= tlct_pkg::LEN_L2C * m2s;
    ki2m2_q  <= tlct_pkg::INER2 * m2s;
    kl1cm1_q <= tlct_pkg::LEN_L1C * m1s;
    kl1m2_q  <= tlct_pkg::LEN_L1 * m2s;
    ki1m1_q  <= tlct_pkg::INER1 * m1s;
  end

  assign acc2_d   = in_i.side.ra1 + in_i.side.ra2;
  assign lwc_full = wc_1 * tlct_pkg::LEN_L1;
  assign lws_full = ws_1 * tlct_pkg::LEN_L1;

  assign v1y_sum = (gc1_2 <<< 10) + (l1cra_2 <<< 12);
  assign v2x_sum = (gs12_2 <<< 10) + ((ta_2 + 2) >>> 2) - 50'((lwc_2 + 8192) >>> 14)
                   - l2w2_2;
  assign v2y_sum = (gc12_2 <<< 10) + ((tb_2 + 2) >>> 2) + 50'((lws_2 + 8192) >>> 14)
                   + (l2acc_2 <<< 12);
  assign v1y_rnd = (v1y_sum + 32768) >>> 16;
  assign v2x_rnd = (v2x_sum + 32768) >>> 16;
  assign v2y_rnd = (v2y_sum + 32768) >>> 16;

  assign u_sum = ((q4_4 + q5_4) + 8192) >>> 14;
  assign u_hi  = u_5[34:16];
  assign u_lo  = {1'b0, u_5[15:0]};

  assign t1_sum = t2_7 + rest_7 + mid_7;
  assign t1_rnd = (t1_sum + (1 <<< 27)) >>> 28;
  assign t2_rnd = (t2_7 + (1 <<< 27)) >>> 28;

  assign o1 = 27'((p1_9 + (1 <<< 23)) >>> 24);
  assign o2 = 27'((p2_9 + (1 <<< 23)) >>> 24);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gc1_1   <= tlct_pkg::GRAV * in_i.c1;
      gs12_1  <= tlct_pkg::GRAV * in_i.s12;
      gc12_1  <= tlct_pkg::GRAV * in_i.c12;
      l1ra_1  <= tlct_pkg::LEN_L1 * in_i.side.ra1;
      l1cra_1 <= tlct_pkg::LEN_L1C * in_i.side.ra1;
      l2acc_1 <= tlct_pkg::LEN_L2C * acc2_d;
      wc_1    <= in_i.side.w1sq * in_i.c2;
      ws_1    <= in_i.side.w1sq * in_i.s2;
      l2w2_1  <= tlct_pkg::LEN_L2C * in_i.side.w2sq;
      acc2_1  <= acc2_d;
      s2_1    <= in_i.s2;
      c2_1    <= in_i.c2;
      ra1_1   <= in_i.side.ra1;
      ra2_1   <= in_i.side.ra2;

      ta_2    <= l1ra_1 * s2_1;
      tb_2    <= l1ra_1 * c2_1;
      lwc_2   <= lwc_full[58:0];
      lws_2   <= lws_full[58:0];
      gc1_2   <= gc1_1;
      gs12_2  <= gs12_1;
      gc12_2  <= gc12_1;
      l1cra_2 <= l1cra_1;
      l2acc_2 <= l2acc_1;
      l2w2_2  <= l2w2_1;
      acc2_2  <= acc2_1;
      s2_2    <= s2_1;
      c2_2    <= c2_1;
      ra1_2   <= ra1_1;
      ra2_2   <= ra2_1;

      v1y_3   <= v1y_rnd[30:0];
      v2x_3   <= v2x_rnd[30:0];
      v2y_3   <= v2y_rnd[30:0];
      acc2_3  <= acc2_2;
      s2_3    <= s2_2;
      c2_3    <= c2_2;
      ra1_3   <= ra1_2;
      ra2_3   <= ra2_2;

      q1_4    <= kl2m2_q * v2y_3;
      q2_4    <= ki2m2_q * acc2_3;
      q3_4    <= kl1cm1_q * v1y_3;
      q4_4    <= s2_3 * v2x_3;
      q5_4    <= c2_3 * v2y_3;
      q6_4    <= ki1m1_q * ra1_3;
      ra1_4   <= ra1_3;
      ra2_4   <= ra2_3;

      u_5     <= u_sum[34:0];
      q1_5    <= q1_4;
      q2_5    <= q2_4;
      q3_5    <= q3_4;
      q6_5    <= q6_4;
      ra1_5   <= ra1_4;
      ra2_5   <= ra2_4;

      uh_6    <= kl1m2_q * u_hi;
      ul_6    <= kl1m2_q * u_lo;
      q1_6    <= q1_5;
      q2_6    <= q2_5;
      q3_6    <= q3_5;
      q6_6    <= q6_5;
      ra1_6   <= ra1_5;
      ra2_6   <= ra2_5;

      mid_7   <= (uh_6 <<< 16) + ul_6;
      t2_7    <= q1_6 + (q2_6 <<< 4);
      rest_7  <= q3_6 + (q6_6 <<< 4);
      ra1_7   <= ra1_6;
      ra2_7   <= ra2_6;

      r1_8    <= t1_rnd[34:0];
      r2_8    <= t2_rnd[34:0];
      ra1_8   <= ra1_7;
      ra2_8   <= ra2_7;

      p1_9    <= r1_8 * torque_scale_i;
      p2_9    <= r2_8 * torque_scale_i;
      ra1_9   <= ra1_8;
      ra2_9   <= ra2_8;

      res_q.torque_one    <= tlct_pkg::sat16(o1);
      res_q.torque_two    <= tlct_pkg::sat16(o2);
      res_q.ref_accel_one <= ra1_9;
      res_q.ref_accel_two <= ra2_9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DYN_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < DYN_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[DYN_LAT-1];
  assign res_o   = res_q;

endmodule

>>> rtl/core/two_link_computed_torque.sv
// ----------------------------------------------------------------------------
// Two-link computed torque controller
// Reference accelerations and Newton-Euler joint torques for a planar
// two-link arm, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output is not
// stalled, and returns its result after reference and angle reduction, the
// rotation pipeline that yields sine and cosine, and the dynamics pipeline.
// A stall on a valid output freezes every stage at once and is passed straight
// back to the input. Register writes take effect for transactions accepted in
// any cycle after the write and must be made while the block is idle.
module two_link_computed_torque (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_addr_i,
  input  logic [tlct_pkg::DW-1:0]        cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [tlct_pkg::DW-1:0] angle_one_i,
  input  logic signed [tlct_pkg::DW-1:0] angle_two_i,
  input  logic signed [tlct_pkg::DW-1:0] rate_one_i,
  input  logic signed [tlct_pkg::DW-1:0] rate_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_angle_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_angle_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_rate_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_rate_two_i,
  input  logic signed [tlct_pkg::DW-1:0] want_accel_one_i,
  input  logic signed [tlct_pkg::DW-1:0] want_accel_two_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [tlct_pkg::DW-1:0] torque_one_o,
  output logic signed [tlct_pkg::DW-1:0] torque_two_o,
  output logic signed [tlct_pkg::DW-1:0] ref_accel_one_o,
  output logic signed [tlct_pkg::DW-1:0] ref_accel_two_o
);

  localparam int unsigned LAST = tlct_pkg::CORDIC_LAT - 1;

  logic [tlct_pkg::DW-1:0] gain_p_q, gain_d_q, mass_first_q, mass_second_q, torque_scale_q;

  logic en;
  logic ref_valid, dyn_valid;
  tlct_pkg::side_t   ref_side;
  tlct_pkg::ang_t    ang1, ang2, ang12;
  tlct_pkg::side_t   side_q [tlct_pkg::CORDIC_LAT];
  logic              sv_q   [tlct_pkg::CORDIC_LAT];
  tlct_pkg::dyn_in_t dyn_in;
  tlct_pkg::res_t    res;
  logic signed [tlct_pkg::SC_W-1:0] c1, s2, c2, s12, c12;

  assign en         = !(dyn_valid && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= tlct_pkg::GAIN_P_RST;
      gain_d_q       <= tlct_pkg::GAIN_D_RST;
      mass_first_q   <= tlct_pkg::MASS_FIRST_RST;
      mass_second_q  <= tlct_pkg::MASS_SECOND_RST;
      torque_scale_q <= tlct_pkg::TORQUE_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tlct_pkg::REG_GAIN_P:       gain_p_q       <= cfg_wdata_i;
        tlct_pkg::REG_GAIN_D:       gain_d_q       <= cfg_wdata_i;
        tlct_pkg::REG_MASS_FIRST:   mass_first_q   <= cfg_wdata_i;
        tlct_pkg::REG_MASS_SECOND:  mass_second_q  <= cfg_wdata_i;
        tlct_pkg::REG_TORQUE_SCALE: torque_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tlct_ref u_ref (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (in_valid_i),
    .angle_one_i      (angle_one_i),
    .angle_two_i      (angle_two_i),
    .rate_one_i       (rate_one_i),
    .rate_two_i       (rate_two_i),
    .want_angle_one_i (want_angle_one_i),
    .want_angle_two_i (want_angle_two_i),
    .want_rate_one_i  (want_rate_one_i),
    .want_rate_two_i  (want_rate_two_i),
    .want_accel_one_i (want_accel_one_i),
    .want_accel_two_i (want_accel_two_i),
    .gain_p_i         ($signed(gain_p_q)),
    .gain_d_i         ($signed(gain_d_q)),
    .valid_o          (ref_valid),
    .side_o           (ref_side),
    .ang1_o           (ang1),
    .ang2_o           (ang2),
    .ang12_o          (ang12)
  );

  tlct_cordic u_cordic_one (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang1),
    .sin_o (),
    .cos_o (c1)
  );

  tlct_cordic u_cordic_two (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang2),
    .sin_o (s2),
    .cos_o (c2)
  );

  tlct_cordic u_cordic_sum (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang12),
    .sin_o (s12),
    .cos_o (c12)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= ref_side;
      for (int i = 1; i < tlct_pkg::CORDIC_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tlct_pkg::CORDIC_LAT; i++) begin
        sv_q[i] <= 1'b0;
      end
    end else if (en) begin
      sv_q[0] <= ref_valid;
      for (int i = 1; i < tlct_pkg::CORDIC_LAT; i++) begin
        sv_q[i] <= sv_q[i-1];
      end
    end
  end

  assign dyn_in.c1   = c1;
  assign dyn_in.s2   = s2;
  assign dyn_in.c2   = c2;
  assign dyn_in.s12  = s12;
  assign dyn_in.c12  = c12;
  assign dyn_in.side = side_q[LAST];

  tlct_dyn u_dyn (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (sv_q[LAST]),
    .in_i           (dyn_in),
    .mass_first_i   (mass_first_q),
    .mass_second_i  (mass_second_q),
    .torque_scale_i ($signed(torque_scale_q)),
    .valid_o        (dyn_valid),
    .res_o          (res)
  );

  assign out_valid_o     = dyn_valid;
  assign torque_one_o    = res.torque_one;
  assign torque_two_o    = res.torque_two;
  assign ref_accel_one_o = res.ref_accel_one;
  assign ref_accel_two_o = res.ref_accel_two;

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_valid |-> (ang12.r <= tlct_pkg::HALF_PI_Q24 && ang12.r >= -tlct_pkg::HALF_PI_Q24))
    else $error("folded angle outside the rotation range");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[LAST] |-> (c1 <= 17'sd16448 && c1 >= -17'sd16448))
    else $error("cosine out of range at the dynamics input");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(c12) && $stable(sv_q[LAST])))
    else $error("rotation pipeline moved during a stall");

endmodule
